[rtl/priority_round_robin_scheduler_top_assert.svh]
// assertion macros shared by the checker
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH

// implication in the same cycle, idle during reset
`define PRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, idle during reset
`define PRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication into the next cycle, also checked across reset
`define PRR_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/prr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package prr_pkg;

  localparam int DEF_PROCESS_SLOTS = 32;
  localparam int DEF_CONTEXT_WIDTH = 32;
  localparam int CFG_IDX_W = 4;

  localparam logic [5:0] PID_KERNEL_CODE = 6'h3F;
  localparam logic [5:0] PID_NONE_CODE   = 6'h3E;

  typedef enum logic [2:0] {
    OP_SWITCH  = 3'd0,
    OP_YIELD   = 3'd1,
    OP_CREATE  = 3'd2,
    OP_KILL    = 3'd3,
    OP_BLOCK   = 3'd4,
    OP_UNBLOCK = 3'd5,
    OP_SETPRIO = 3'd6,
    OP_INFO    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_KILLED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RK_SLOT   = 2'd0,
    RK_KERNEL = 2'd1,
    RK_NONE   = 2'd2
  } run_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGHEST  = 4'd0,
    CFG_LOWEST   = 4'd1,
    CFG_DEFAULT  = 4'd2,
    CFG_REALTIME = 4'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_RD,
    S_OP_EX,
    S_SV_RD,
    S_SV_WR,
    S_FC_RD,
    S_FC_EX,
    S_SCAN,
    S_DONE
  } state_t;

  function automatic logic [3:0] grant(input logic [3:0] lo, input logic [3:0] p);
    return (lo > p) ? (lo - p) : 4'd0;
  endfunction

endpackage
`default_nettype wire

[rtl/prr_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
interface prr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [4:0]  pid_index;
  logic [3:0]  priority_value;
  logic [31:0] context_handle;
  modport source (output valid, opcode, pid_index, priority_value, context_handle,
                  input ready);
  modport sink (input valid, opcode, pid_index, priority_value, context_handle,
                output ready);
endinterface

interface prr_out_if;
  logic              valid;
  logic              ready;
  logic              error_flag;
  logic signed [5:0] running_pid;
  logic [31:0]       context_out;
  logic [1:0]        info_status;
  logic [3:0]        info_priority;
  modport source (output valid, error_flag, running_pid, context_out, info_status,
                  info_priority, input ready);
  modport sink (input valid, error_flag, running_pid, context_out, info_status,
                info_priority, output ready);
endinterface

interface prr_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [3:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/prr_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module prr_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 38,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/prr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module prr_ctrl
  import prr_pkg::*;
#(
  parameter int PS = DEF_PROCESS_SLOTS,
  parameter int CW = DEF_CONTEXT_WIDTH,
  parameter int IW = $clog2(PS),
  parameter int EW = CW + 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [4:0]            in_pid,
  input  wire logic [3:0]            in_prio,
  input  wire logic [31:0]           in_ctx,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [3:0]            cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_err,
  output logic [5:0]                 out_pid,
  output logic [31:0]                out_ctx,
  output logic [1:0]                 out_st,
  output logic [3:0]                 out_pr,
  output logic                       mem_rd_en,
  output logic [IW-1:0]              mem_rd_addr,
  input  wire logic [EW-1:0]         mem_rd_data,
  output logic                       mem_wr_en,
  output logic [IW-1:0]              mem_wr_addr,
  output logic [EW-1:0]              mem_wr_data
);

  localparam int PW    = IW + 5;
  localparam int CNT_W = $clog2(PS + 1);

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [IW-1:0]       pid_r, pid_nxt;
  logic                pid_ok_r, pid_ok_nxt;
  logic [3:0]          prio_r, prio_nxt;
  logic [CW-1:0]       ctx_r, ctx_nxt;
  logic [PS-1:0]       act_r, act_nxt;
  run_kind_t           run_kind_r, run_kind_nxt;
  logic [IW-1:0]       run_idx_r, run_idx_nxt;
  run_kind_t           frc_kind_r, frc_kind_nxt;
  logic [IW-1:0]       frc_idx_r, frc_idx_nxt;
  logic [3:0]          quant_r, quant_nxt;
  logic [CW-1:0]       kctx_r, kctx_nxt;
  logic [3:0]          hi_r, hi_nxt, lo_r, lo_nxt, def_r, def_nxt, rt_r, rt_nxt;
  status_t             cur_st_r, cur_st_nxt;
  logic [3:0]          cur_pr_r, cur_pr_nxt;
  logic [IW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [IW-1:0]       chk_idx_r, chk_idx_nxt;
  logic                err_r, err_nxt;
  logic [31:0]         cout_r, cout_nxt;
  logic [1:0]          ist_r, ist_nxt;
  logic [3:0]          ipr_r, ipr_nxt;
  logic                ov_r, ov_nxt;
  logic                oerr_r, oerr_nxt;
  logic [5:0]          opid_r, opid_nxt;
  logic [31:0]         octx_r, octx_nxt;
  logic [1:0]          ost_r, ost_nxt;
  logic [3:0]          opr_r, opr_nxt;

  logic [PW-1:0]       pid_ext;
  logic                in_acc;
  logic                act;
  logic [CW-1:0]       rd_ctx;
  logic [3:0]          rd_pr;
  status_t             rd_st;
  status_t             sv_st;
  logic                f_ok, keep_ok, hit, load;
  logic [3:0]          new_pr;
  logic [IW-1:0]       first, first_nxt;
  logic [IW+5:0]       run_pad;

  assign pid_ext = {{IW{1'b0}}, in_pid};
  assign in_acc  = in_valid && in_ready;
  assign rd_ctx  = mem_rd_data[CW-1:0];
  assign rd_pr   = mem_rd_data[CW+3:CW];
  assign rd_st   = status_t'(mem_rd_data[CW+5:CW+4]);
  assign act     = pid_ok_r && act_r[pid_r];
  assign sv_st   = (rd_st == ST_RUNNING) ? ST_READY : rd_st;
  assign new_pr  = (prio_r < hi_r || prio_r > lo_r) ? def_r : prio_r;
  assign f_ok    = (frc_kind_r == RK_SLOT) && act_r[frc_idx_r] && (rd_st == ST_READY);
  assign keep_ok = (run_kind_r == RK_SLOT) && act_r[run_idx_r] && (cur_st_r == ST_READY)
                   && (quant_r != 4'd0);
  assign hit     = chk_v_r && act_r[chk_idx_r] && (rd_st == ST_READY);
  assign first   = (run_kind_r == RK_SLOT) ? run_idx_r : '0;
  assign first_nxt = (first == IW'(PS - 1)) ? '0 : first + 1'b1;
  assign load    = (state_r == S_DONE) && (!ov_r || out_ready);
  assign run_pad = {6'd0, run_idx_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (op_t'(in_opcode) == OP_SWITCH || op_t'(in_opcode) == OP_YIELD) begin
            state_nxt = S_SV_RD;
          end else begin
            state_nxt = S_OP_RD;
          end
        end
      end
      S_OP_RD: state_nxt = S_OP_EX;
      S_OP_EX: state_nxt = S_DONE;
      S_SV_RD: state_nxt = S_SV_WR;
      S_SV_WR: state_nxt = S_FC_RD;
      S_FC_RD: state_nxt = S_FC_EX;
      S_FC_EX: state_nxt = (f_ok || keep_ok) ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (hit || (!chk_v_r && iss_cnt_r == CNT_W'(PS))) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready     = (state_r == S_IDLE);
    op_nxt       = op_r;
    pid_nxt      = pid_r;
    pid_ok_nxt   = pid_ok_r;
    prio_nxt     = prio_r;
    ctx_nxt      = ctx_r;
    act_nxt      = act_r;
    run_kind_nxt = run_kind_r;
    run_idx_nxt  = run_idx_r;
    frc_kind_nxt = frc_kind_r;
    frc_idx_nxt  = frc_idx_r;
    quant_nxt    = quant_r;
    kctx_nxt     = kctx_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    def_nxt      = def_r;
    rt_nxt       = rt_r;
    cur_st_nxt   = cur_st_r;
    cur_pr_nxt   = cur_pr_r;
    scan_idx_nxt = scan_idx_r;
    iss_cnt_nxt  = iss_cnt_r;
    chk_v_nxt    = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    err_nxt      = err_r;
    cout_nxt     = cout_r;
    ist_nxt      = ist_r;
    ipr_nxt      = ipr_r;
    ov_nxt       = ov_r;
    oerr_nxt     = oerr_r;
    opid_nxt     = opid_r;
    octx_nxt     = octx_r;
    ost_nxt      = ost_r;
    opr_nxt      = opr_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = pid_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = pid_r;
    mem_wr_data  = {rd_st, rd_pr, rd_ctx};

    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HIGHEST:  hi_nxt  = cfg_data;
        CFG_LOWEST:   lo_nxt  = cfg_data;
        CFG_DEFAULT:  def_nxt = cfg_data;
        CFG_REALTIME: rt_nxt  = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt     = op_t'(in_opcode);
          pid_nxt    = pid_ext[IW-1:0];
          pid_ok_nxt = (pid_ext < PW'(PS));
          prio_nxt   = in_prio;
          ctx_nxt    = CW'(in_ctx);
          err_nxt    = 1'b0;
          cout_nxt   = '0;
          ist_nxt    = '0;
          ipr_nxt    = '0;
          if (op_t'(in_opcode) == OP_YIELD) begin
            quant_nxt = 4'd0;
          end
        end
      end
      S_OP_RD: begin
        mem_rd_en = pid_ok_r;
      end
      S_OP_EX: begin
        case (op_r)
          OP_CREATE: begin
            if (!pid_ok_r) begin
              err_nxt = 1'b1;
            end else begin
              mem_wr_en      = 1'b1;
              mem_wr_data    = {ST_READY, new_pr, ctx_r};
              act_nxt[pid_r] = 1'b1;
            end
          end
          OP_KILL: begin
            if (!act) begin
              err_nxt = 1'b1;
            end else if (rd_st != ST_KILLED) begin
              mem_wr_en      = 1'b1;
              mem_wr_data    = {ST_KILLED, rd_pr, rd_ctx};
              act_nxt[pid_r] = 1'b0;
              if (run_kind_r == RK_SLOT && run_idx_r == pid_r) begin
                run_kind_nxt = RK_NONE;
              end
            end
          end
          OP_BLOCK: begin
            if (!act) begin
              err_nxt = 1'b1;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {ST_BLOCKED, rd_pr, rd_ctx};
              if (run_kind_r == RK_SLOT && run_idx_r == pid_r) begin
                quant_nxt = 4'd0;
              end
            end
          end
          OP_UNBLOCK: begin
            if (!act) begin
              err_nxt = 1'b1;
            end else if (rd_st == ST_BLOCKED || rd_st == ST_KILLED) begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {ST_READY, rd_pr, rd_ctx};
              if (rd_pr <= rt_r) begin
                frc_kind_nxt = RK_SLOT;
                frc_idx_nxt  = pid_r;
              end
            end
          end
          OP_SETPRIO: begin
            if (!act || prio_r < hi_r || prio_r > lo_r) begin
              err_nxt = 1'b1;
            end else begin
              mem_wr_en   = 1'b1;
              mem_wr_data = {rd_st, prio_r, rd_ctx};
            end
          end
          OP_INFO: begin
            if (!act) begin
              err_nxt = 1'b1;
            end else begin
              cout_nxt = 32'(rd_ctx);
              ist_nxt  = rd_st;
              ipr_nxt  = rd_pr;
            end
          end
          default: ;
        endcase
      end
      S_SV_RD: begin
        mem_rd_addr = run_idx_r;
        if (run_kind_r == RK_SLOT) begin
          mem_rd_en = 1'b1;
        end else if (run_kind_r == RK_KERNEL) begin
          kctx_nxt = ctx_r;
        end
      end
      S_SV_WR: begin
        // save outgoing context, running drops back to ready
        mem_wr_addr = run_idx_r;
        mem_wr_data = {sv_st, rd_pr, ctx_r};
        cur_st_nxt  = sv_st;
        cur_pr_nxt  = rd_pr;
        mem_wr_en   = (run_kind_r == RK_SLOT);
      end
      S_FC_RD: begin
        mem_rd_addr = frc_idx_r;
        mem_rd_en   = (frc_kind_r == RK_SLOT);
      end
      S_FC_EX: begin
        if (f_ok) begin
          run_kind_nxt = RK_SLOT;
          run_idx_nxt  = frc_idx_r;
          frc_kind_nxt = RK_NONE;
          quant_nxt    = grant(lo_r, rd_pr);
          mem_wr_en    = 1'b1;
          mem_wr_addr  = frc_idx_r;
          mem_wr_data  = {ST_RUNNING, rd_pr, rd_ctx};
          cout_nxt     = 32'(rd_ctx);
        end else if (keep_ok) begin
          quant_nxt   = quant_r - 4'd1;
          mem_wr_en   = 1'b1;
          mem_wr_addr = run_idx_r;
          mem_wr_data = {ST_RUNNING, cur_pr_r, ctx_r};
          cout_nxt    = 32'(ctx_r);
        end else begin
          scan_idx_nxt = first_nxt;
          iss_cnt_nxt  = '0;
        end
      end
      S_SCAN: begin
        // one read issued per cycle, checked the cycle after
        mem_rd_addr = scan_idx_r;
        if (iss_cnt_r != CNT_W'(PS)) begin
          mem_rd_en    = 1'b1;
          chk_v_nxt    = 1'b1;
          chk_idx_nxt  = scan_idx_r;
          iss_cnt_nxt  = iss_cnt_r + 1'b1;
          scan_idx_nxt = (scan_idx_r == IW'(PS - 1)) ? '0 : scan_idx_r + 1'b1;
        end
        if (hit) begin
          run_kind_nxt = RK_SLOT;
          run_idx_nxt  = chk_idx_r;
          quant_nxt    = grant(lo_r, rd_pr);
          mem_wr_en    = 1'b1;
          mem_wr_addr  = chk_idx_r;
          mem_wr_data  = {ST_RUNNING, rd_pr, rd_ctx};
          cout_nxt     = 32'(rd_ctx);
        end else if (!chk_v_r && iss_cnt_r == CNT_W'(PS)) begin
          run_kind_nxt = RK_KERNEL;
          quant_nxt    = 4'd0;
          cout_nxt     = 32'(kctx_r);
        end
      end
      S_DONE: ;
      default: ;
    endcase

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt   = 1'b1;
      oerr_nxt = err_r;
      octx_nxt = cout_r;
      ost_nxt  = ist_r;
      opr_nxt  = ipr_r;
      case (run_kind_r)
        RK_SLOT:   opid_nxt = run_pad[5:0];
        RK_KERNEL: opid_nxt = PID_KERNEL_CODE;
        default:   opid_nxt = PID_NONE_CODE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      act_r      <= '0;
      run_kind_r <= RK_KERNEL;
      run_idx_r  <= '0;
      frc_kind_r <= RK_NONE;
      frc_idx_r  <= '0;
      quant_r    <= 4'd0;
      kctx_r     <= '0;
      hi_r       <= 4'd0;
      lo_r       <= 4'd10;
      def_r      <= 4'd4;
      rt_r       <= 4'd1;
      chk_v_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      act_r      <= act_nxt;
      run_kind_r <= run_kind_nxt;
      run_idx_r  <= run_idx_nxt;
      frc_kind_r <= frc_kind_nxt;
      frc_idx_r  <= frc_idx_nxt;
      quant_r    <= quant_nxt;
      kctx_r     <= kctx_nxt;
      hi_r       <= hi_nxt;
      lo_r       <= lo_nxt;
      def_r      <= def_nxt;
      rt_r       <= rt_nxt;
      chk_v_r    <= chk_v_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    pid_ok_r   <= pid_ok_nxt;
    prio_r     <= prio_nxt;
    ctx_r      <= ctx_nxt;
    cur_st_r   <= cur_st_nxt;
    cur_pr_r   <= cur_pr_nxt;
    scan_idx_r <= scan_idx_nxt;
    iss_cnt_r  <= iss_cnt_nxt;
    chk_idx_r  <= chk_idx_nxt;
    err_r      <= err_nxt;
    cout_r     <= cout_nxt;
    ist_r      <= ist_nxt;
    ipr_r      <= ipr_nxt;
    oerr_r     <= oerr_nxt;
    opid_r     <= opid_nxt;
    octx_r     <= octx_nxt;
    ost_r      <= ost_nxt;
    opr_r      <= opr_nxt;
  end

  assign out_valid = ov_r;
  assign out_err   = oerr_r;
  assign out_pid   = opid_r;
  assign out_ctx   = octx_r;
  assign out_st    = ost_r;
  assign out_pr    = opr_r;

endmodule
`default_nettype wire

[rtl/priority_round_robin_scheduler_top.sv]
// table ops: accept, OP_RD, OP_EX, DONE, result word; switch and yield: accept, SV_RD,
// SV_WR, FC_RD, FC_EX, SCAN unless the forced or current slot is served, DONE;
// input taken only in IDLE; the scan reads one slot per cycle from the table ram
// reset: synchronous active low, clears active bits, runner to kernel, no forced slot,
// quantum and kernel context to zero, config to defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module priority_round_robin_scheduler_top
  import prr_pkg::*;
#(
  parameter int PROCESS_SLOTS = DEF_PROCESS_SLOTS,
  parameter int CONTEXT_WIDTH = DEF_CONTEXT_WIDTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  prr_in_if.sink     in_bus,
  prr_out_if.source  out_bus,
  prr_cfg_if.sink    cfg_bus
);

  localparam int IW = $clog2(PROCESS_SLOTS);
  localparam int EW = CONTEXT_WIDTH + 6;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] rd_data, wr_data;
  logic [5:0]    run_pid;

  assign cfg_bus.ready       = 1'b1;
  assign out_bus.running_pid = signed'(run_pid);

  prr_ctrl #(
    .PS (PROCESS_SLOTS),
    .CW (CONTEXT_WIDTH),
    .IW (IW),
    .EW (EW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_opcode   (in_bus.opcode),
    .in_pid      (in_bus.pid_index),
    .in_prio     (in_bus.priority_value),
    .in_ctx      (in_bus.context_handle),
    .cfg_valid   (cfg_bus.valid),
    .cfg_index   (cfg_bus.index),
    .cfg_data    (cfg_bus.data),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_err     (out_bus.error_flag),
    .out_pid     (run_pid),
    .out_ctx     (out_bus.context_out),
    .out_st      (out_bus.info_status),
    .out_pr      (out_bus.info_priority),
    .mem_rd_en   (rd_en),
    .mem_rd_addr (rd_addr),
    .mem_rd_data (rd_data),
    .mem_wr_en   (wr_en),
    .mem_wr_addr (wr_addr),
    .mem_wr_data (wr_data)
  );

  prr_mem #(
    .DEPTH (PROCESS_SLOTS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
`default_nettype wire

[rtl/prr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "priority_round_robin_scheduler_top_assert.svh"
module prr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        error_flag,
  input wire logic [31:0] context_out,
  input wire logic [1:0]  info_status,
  input wire logic [3:0]  info_priority
);

  // one word in flight: no new word right after one is taken
  `PRR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted twice in a row")
  `PRR_ASSERT_NOW(a_err_clean, out_valid && error_flag,
    context_out == 32'd0 && info_status == 2'd0 && info_priority == 4'd0,
    "error word carries payload")
  `PRR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(context_out) && $stable(error_flag), "stalled result changed")
  `PRR_ASSERT_ALWAYS(a_rst_out, !rst_n, !out_valid, "result valid after reset")

endmodule

bind priority_round_robin_scheduler_top prr_checker u_prr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .error_flag    (out_bus.error_flag),
  .context_out   (out_bus.context_out),
  .info_status   (out_bus.info_status),
  .info_priority (out_bus.info_priority)
);
`default_nettype wire

[tb/priority_round_robin_scheduler_top_tb.sv]
`timescale 1ns / 1ps
module priority_round_robin_scheduler_top_tb;
  import prr_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic        err;
    logic [5:0]  pid;
    logic [31:0] ctx;
    logic [1:0]  st;
    logic [3:0]  pr;
  } sched_result_t;

  logic clk;
  logic rst_n;

  prr_in_if  in_if ();
  prr_out_if out_if ();
  prr_cfg_if cfg_if ();

  priority_round_robin_scheduler_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if),
    .out_bus(out_if),
    .cfg_bus(cfg_if)
  );

  // shadow of the scheduler
  logic [3:0]  prio_hi, prio_lo, prio_def, rt_limit;
  logic        sh_active[SLOTS];
  status_t     sh_status[SLOTS];
  logic [3:0]  sh_prio[SLOTS];
  logic [31:0] sh_ctx[SLOTS];
  int          sh_running;
  int          sh_forced;
  logic [3:0]  sh_quantum;
  logic [31:0] sh_kernel_ctx;

  sched_result_t pending_results[$];
  int errors;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("priority_round_robin_scheduler_top verification failed");
    $finish;
  end

  function automatic bit slot_ready(int s);
    return s >= 0 && s < SLOTS && sh_active[s] && sh_status[s] == ST_READY;
  endfunction

  function automatic logic [3:0] quantum_for(int s);
    return (prio_lo > sh_prio[s]) ? prio_lo - sh_prio[s] : 4'd0;
  endfunction

  function automatic int scan_next_ready();
    int first;
    int n;
    first = (sh_running < 0) ? 0 : sh_running;
    n = first;
    do begin
      n = (n + 1) % SLOTS;
      if (slot_ready(n)) return n;
    end while (n != first);
    return -1;
  endfunction

  function automatic logic [31:0] context_switch(logic [31:0] ctx);
    if (sh_running >= 0) begin
      sh_ctx[sh_running] = ctx;
      if (sh_status[sh_running] == ST_RUNNING) sh_status[sh_running] = ST_READY;
    end else if (sh_running == -1) begin
      sh_kernel_ctx = ctx;
    end
    if (slot_ready(sh_forced)) begin
      sh_running = sh_forced;
      sh_forced = -2;
      sh_quantum = quantum_for(sh_running);
    end else if (!slot_ready(sh_running) || sh_quantum == 4'd0) begin
      sh_running = scan_next_ready();
      if (sh_running == -1) begin
        sh_quantum = 4'd0;
        return sh_kernel_ctx;
      end
      sh_quantum = quantum_for(sh_running);
    end else begin
      sh_quantum = sh_quantum - 4'd1;
    end
    sh_status[sh_running] = ST_RUNNING;
    return sh_ctx[sh_running];
  endfunction

  function automatic sched_result_t schedule_step(op_t op, int pid, logic [3:0] prio,
                                                  logic [31:0] ctx);
    sched_result_t r;
    bit act;
    r = '0;
    act = sh_active[pid];
    case (op)
      OP_YIELD: begin
        sh_quantum = 4'd0;
        r.ctx = context_switch(ctx);
      end
      OP_SWITCH: r.ctx = context_switch(ctx);
      OP_CREATE: begin
        if (prio < prio_hi || prio > prio_lo) prio = prio_def;
        sh_prio[pid] = prio;
        sh_status[pid] = ST_READY;
        sh_ctx[pid] = ctx;
        sh_active[pid] = 1'b1;
      end
      OP_KILL: begin
        if (!act) r.err = 1'b1;
        else if (sh_status[pid] != ST_KILLED) begin
          sh_status[pid] = ST_KILLED;
          sh_active[pid] = 1'b0;
          if (sh_running == pid) sh_running = -2;
        end
      end
      OP_BLOCK: begin
        if (!act) r.err = 1'b1;
        else begin
          sh_status[pid] = ST_BLOCKED;
          if (sh_running == pid) sh_quantum = 4'd0;
        end
      end
      OP_UNBLOCK: begin
        if (!act) r.err = 1'b1;
        else if (sh_status[pid] != ST_READY && sh_status[pid] != ST_RUNNING) begin
          if (sh_prio[pid] <= rt_limit) sh_forced = pid;
          sh_status[pid] = ST_READY;
        end
      end
      OP_SETPRIO: begin
        if (!act || prio < prio_hi || prio > prio_lo) r.err = 1'b1;
        else sh_prio[pid] = prio;
      end
      default: begin
        if (!act) r.err = 1'b1;
        else begin
          r.ctx = sh_ctx[pid];
          r.st = sh_status[pid];
          r.pr = sh_prio[pid];
        end
      end
    endcase
    r.pid = sh_running[5:0];
    return r;
  endfunction

  // receiver side
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) rx_hold_cycles <= rx_hold_cycles - 1;
    out_if.ready <= (rx_hold_cycles == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word pid=%0d", $time, out_if.running_pid);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.error_flag !== exp_r.err || out_if.running_pid !== exp_r.pid ||
            out_if.context_out !== exp_r.ctx || out_if.info_status !== exp_r.st ||
            out_if.info_priority !== exp_r.pr) begin
          $display("%0t: mismatch expected err=%0b pid=%0d ctx=%h st=%0d pr=%0d",
                   $time, exp_r.err, $signed(exp_r.pid), exp_r.ctx, exp_r.st, exp_r.pr);
          $display("%0t:          actual   err=%0b pid=%0d ctx=%h st=%0d pr=%0d",
                   $time, out_if.error_flag, out_if.running_pid, out_if.context_out,
                   out_if.info_status, out_if.info_priority);
          errors++;
        end
      end
    end
  end

  task automatic send_op(op_t op, int pid, logic [3:0] prio, logic [31:0] ctx);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.opcode = op;
    in_if.pid_index = pid[4:0];
    in_if.priority_value = prio;
    in_if.context_handle = ctx;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(schedule_step(op, pid, prio, ctx));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [3:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_HIGHEST: prio_hi = val;
      CFG_LOWEST: prio_lo = val;
      CFG_DEFAULT: prio_def = val;
      default: rt_limit = val;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_levels(logic [3:0] hi, logic [3:0] lo, logic [3:0] def,
                            logic [3:0] rt);
    write_reg(CFG_HIGHEST, hi);
    write_reg(CFG_LOWEST, lo);
    write_reg(CFG_DEFAULT, def);
    write_reg(CFG_REALTIME, rt);
  endtask

  // mostly lifecycle traffic on a few slots, some noise on the whole table
  task automatic send_random_op();
    int pick;
    int pid;
    op_t op;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_SWITCH;
    else if (pick < 38) op = OP_YIELD;
    else if (pick < 55) op = OP_CREATE;
    else if (pick < 62) op = OP_KILL;
    else if (pick < 72) op = OP_BLOCK;
    else if (pick < 82) op = OP_UNBLOCK;
    else if (pick < 90) op = OP_SETPRIO;
    else op = OP_INFO;
    pid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
    send_op(op, pid, 4'($urandom_range(0, 15)), $urandom());
  endtask

  task automatic test_directed();
    send_op(OP_SWITCH, 0, 0, 32'hFFFF_FFFF);
    send_op(OP_INFO, 3, 0, 0);
    send_op(OP_KILL, 31, 0, 0);
    send_op(OP_CREATE, 0, 4'd0, 32'h0000_0000);
    send_op(OP_CREATE, 31, 4'd15, 32'hFFFF_FFFF);
    send_op(OP_CREATE, 7, 4'd10, 32'hA5A5_5A5A);
    send_op(OP_INFO, 31, 0, 0);
    send_op(OP_SETPRIO, 7, 4'd11, 0);
    send_op(OP_SETPRIO, 7, 4'd9, 0);
    send_op(OP_SWITCH, 0, 0, 32'h1234_5678);
    send_op(OP_SWITCH, 0, 0, 32'h0BAD_F00D);
    send_op(OP_YIELD, 0, 0, 32'h5555_AAAA);
    send_op(OP_BLOCK, 0, 0, 0);
    send_op(OP_UNBLOCK, 31, 0, 0);
    send_op(OP_UNBLOCK, 0, 0, 0);
    send_op(OP_SWITCH, 0, 0, 32'h8000_0001);
    send_op(OP_INFO, 0, 0, 0);
    send_op(OP_KILL, 0, 0, 0);
    send_op(OP_SWITCH, 0, 0, 32'hDEAD_BEEF);
    send_op(OP_KILL, 0, 0, 0);
    send_op(OP_CREATE, 31, 4'd2, 32'h7FFF_FFFF);
    send_op(OP_SETPRIO, 2, 4'd3, 0);
    send_op(OP_YIELD, 0, 0, 32'hCAFE_0000);
    send_op(OP_INFO, 31, 0, 0);
    wait_drained();
  endtask

  task automatic test_level_extremes();
    // inverted range: every create falls back to the default, every set-priority is refused
    set_levels(4'd15, 4'd0, 4'd15, 4'd15);
    repeat (60) send_random_op();
    wait_drained();
    set_levels(4'd0, 4'd15, 4'd0, 4'd0);
    repeat (60) send_random_op();
    wait_drained();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    set_levels(4'($urandom_range(0, 4)), 4'($urandom_range(6, 15)),
               4'($urandom_range(0, 15)), 4'($urandom_range(0, 5)));
    repeat (n) send_random_op();
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_cycles = 400;
    repeat (40) send_random_op();
    wait_drained();
    repeat (20) send_random_op();
    wait_drained();
  endtask

  initial begin
    errors = 0;
    tx_idle_pct = 15;
    rx_idle_pct = 54;
    rx_hold_cycles = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_SWITCH;
    in_if.pid_index = '0;
    in_if.priority_value = '0;
    in_if.context_handle = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_HIGHEST;
    cfg_if.data = '0;
    prio_hi = 4'd0;
    prio_lo = 4'd10;
    prio_def = 4'd4;
    rt_limit = 4'd1;
    for (int i = 0; i < SLOTS; i++) begin
      sh_active[i] = 1'b0;
      sh_status[i] = ST_READY;
      sh_prio[i] = '0;
      sh_ctx[i] = '0;
    end
    sh_running = -1;
    sh_forced = -2;
    sh_quantum = '0;
    sh_kernel_ctx = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_level_extremes();
    test_random_traffic(15, 54, 450);
    test_backpressure();
    test_random_traffic(54, 15, 450);
    test_random_traffic(0, 0, 450);
    set_levels(4'd0, 4'd10, 4'd4, 4'd1);
    repeat (50) send_random_op();
    wait_drained();

    if (errors == 0) begin
      $display("priority_round_robin_scheduler_top verification clean");
    end else begin
      $display("priority_round_robin_scheduler_top verification failed");
    end
    $finish;
  end

endmodule
